/* sv/orthonormalize_three_axes_unit_assert.svh */
// Assertion macros shared by the orthonormalization unit.
`ifndef ORTHONORMALIZE_THREE_AXES_UNIT_ASSERT_SVH
`define ORTHONORMALIZE_THREE_AXES_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ORTHO3_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ORTHO3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ortho3_pkg.sv */
// Shared widths, latencies and types of the orthonormalization unit.
package ortho3_pkg;

  // Vector components entering a normalizer or a projection stage.
  localparam int VEC_W = 33;
  // Component magnitudes after clamping to 2^31.
  localparam int MAG_W = 32;
  // Unit vector components in signed Q2.30.
  localparam int UNIT_W = 32;
  localparam int FRAC = 30;
  // Sum of squares and its integer square root.
  localparam int SQ_W = 64;
  localparam int ROOT_W = 32;
  localparam int SQRT_STEPS = 32;
  // Long division of (mag << 30) + norm / 2 by the norm.
  localparam int QUO_W = 31;
  localparam int DIV_STEPS = QUO_W;
  localparam int NUM_W = MAG_W + FRAC;
  localparam int REM_W = ROOT_W + 1;
  // Residuals with no component above this many LSBs count as zero length.
  localparam int DEGEN_TOL = 256;
  // Output format.
  localparam int OUT_W = 16;
  localparam int OUT_SHIFT = 16;
  localparam int OUT_MAX = 16384;

  // Register stages of each unit.
  localparam int NORM_LAT = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int PROJ_LAT = 5;

  typedef logic signed [VEC_W-1:0] vec_comp_t;
  typedef logic signed [UNIT_W-1:0] unit_comp_t;

endpackage

/* sv/ortho3_norm.sv */
// Pipelined vector normalizer: clamp, scale up, square root, three long divisions.
module ortho3_norm import ortho3_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic       use_tol,
  input  vec_comp_t  vin [3],
  output unit_comp_t uout [3],
  output logic       zero
);

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

  localparam vec_comp_t CLAMP_HI = vec_comp_t'(64'sd2147483648);

  // Stage 0: clamp, split sign and magnitude, find the largest magnitude.
  logic [MAG_W-1:0] c_mag [3];
  logic [2:0]       c_neg;
  logic [MAG_W-1:0] c_max;
  logic             c_zero;

  always_comb begin
    vec_comp_t clamped;
    vec_comp_t absval;
    c_max = '0;
    for (int i = 0; i < 3; i++) begin
      clamped = vin[i];
      if (vin[i] > CLAMP_HI) begin
        clamped = CLAMP_HI;
      end else if (vin[i] < -CLAMP_HI) begin
        clamped = -CLAMP_HI;
      end
      c_neg[i] = clamped[VEC_W-1];
      absval = c_neg[i] ? -clamped : clamped;
      c_mag[i] = absval[MAG_W-1:0];
      if (c_mag[i] > c_max) begin
        c_max = c_mag[i];
      end
    end
    c_zero = use_tol ? (c_max <= MAG_W'(DEGEN_TOL)) : (c_max == '0);
  end

  logic [MAG_W-1:0] s0_mag [3];
  logic [MAG_W-1:0] s0_max;
  side_t            s0_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mag  <= c_mag;
      s0_max  <= c_max;
      s0_side <= '{neg: c_neg, zero: c_zero};
    end
  end

  // Stages 1 and 2: double until the largest magnitude reaches 2^30,
  // as coarse shifts by 16 and 8, then by 4, 2 and 1.
  logic [MAG_W-1:0] a_mag [3];
  logic [MAG_W-1:0] a_max;

  always_comb begin
    a_mag = s0_mag;
    a_max = s0_max;
    for (int s = 0; s < 2; s++) begin
      if (a_max < (MAG_W'(1) << (MAG_W - 1 - (16 >> s)))) begin
        a_max = a_max << (16 >> s);
        for (int i = 0; i < 3; i++) begin
          a_mag[i] = a_mag[i] << (16 >> s);
        end
      end
    end
  end

  logic [MAG_W-1:0] s1_mag [3];
  logic [MAG_W-1:0] s1_max;
  side_t            s1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag  <= a_mag;
      s1_max  <= a_max;
      s1_side <= s0_side;
    end
  end

  logic [MAG_W-1:0] b_mag [3];

  always_comb begin
    logic [MAG_W-1:0] b_max;
    b_mag = s1_mag;
    b_max = s1_max;
    for (int s = 2; s < 5; s++) begin
      if (b_max < (MAG_W'(1) << (MAG_W - 1 - (16 >> s)))) begin
        b_max = b_max << (16 >> s);
        for (int i = 0; i < 3; i++) begin
          b_mag[i] = b_mag[i] << (16 >> s);
        end
      end
    end
  end

  logic [MAG_W-1:0] s2_mag [3];
  side_t            s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag  <= b_mag;
      s2_side <= s1_side;
    end
  end

  // Stage 3: squares of the scaled magnitudes.
  logic [SQ_W-1:0]  sq_c [3];
  logic [SQ_W-1:0]  s3_sq [3];
  logic [MAG_W-1:0] s3_mag [3];
  side_t            s3_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_c[i] = SQ_W'(s2_mag[i]) * SQ_W'(s2_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sq   <= sq_c;
      s3_mag  <= s2_mag;
      s3_side <= s2_side;
    end
  end

  // Stage 4 sums the squares; each root stage adds one result bit of the floor square root.
  logic [SQ_W-1:0]  rt_v    [SQRT_STEPS+1];
  logic [SQ_W-1:0]  rt_r    [SQRT_STEPS+1];
  logic [MAG_W-1:0] rt_mag  [SQRT_STEPS+1][3];
  side_t            rt_side [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rt_v[0]    <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      rt_r[0]    <= '0;
      rt_mag[0]  <= s3_mag;
      rt_side[0] <= s3_side;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    assign trial = rt_r[j] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rt_v[j] >= trial) begin
          rt_v[j+1] <= rt_v[j] - trial;
          rt_r[j+1] <= (rt_r[j] >> 1) + BIT;
        end else begin
          rt_v[j+1] <= rt_v[j];
          rt_r[j+1] <= rt_r[j] >> 1;
        end
        rt_mag[j+1]  <= rt_mag[j];
        rt_side[j+1] <= rt_side[j];
      end
    end
  end

  // Division setup: dividend carries the half-divisor term for rounding.
  logic [ROOT_W-1:0] norm;
  logic [NUM_W-1:0]  prep_num [3];

  assign norm = rt_r[SQRT_STEPS][ROOT_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prep_num[i] = {rt_mag[SQRT_STEPS][i], FRAC'(0)} + NUM_W'(norm >> 1);
    end
  end

  logic [NUM_W-1:0]  dv_num  [DIV_STEPS+1][3];
  logic [REM_W-1:0]  dv_rem  [DIV_STEPS+1][3];
  logic [QUO_W-1:0]  dv_q    [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dv_den  [DIV_STEPS+1];
  side_t             dv_side [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_num[0][i] <= prep_num[i];
        dv_rem[0][i] <= REM_W'(prep_num[i][NUM_W-1:QUO_W]);
        dv_q[0][i]   <= '0;
      end
      dv_den[0]  <= norm;
      dv_side[0] <= rt_side[SQRT_STEPS];
    end
  end

  // Division stages: one quotient bit per stage in each of the three lanes.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int QB = QUO_W - 1 - j;
    logic [REM_W-1:0] rem_sh [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_sh[i] = {dv_rem[j][i][REM_W-2:0], dv_num[j][i][QB]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_sh[i] >= {1'b0, dv_den[j]}) begin
            dv_rem[j+1][i] <= rem_sh[i] - {1'b0, dv_den[j]};
            dv_q[j+1][i]   <= dv_q[j][i] | (QUO_W'(1) << QB);
          end else begin
            dv_rem[j+1][i] <= rem_sh[i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_num[j+1]  <= dv_num[j];
        dv_den[j+1]  <= dv_den[j];
        dv_side[j+1] <= dv_side[j];
      end
    end
  end

  // Output stage: restore signs; a degenerate vector gives zeros.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_side[DIV_STEPS].zero) begin
          uout[i] <= '0;
        end else if (dv_side[DIV_STEPS].neg[i]) begin
          uout[i] <= -$signed({1'b0, dv_q[DIV_STEPS][i]});
        end else begin
          uout[i] <= $signed({1'b0, dv_q[DIV_STEPS][i]});
        end
      end
      zero <= dv_side[DIV_STEPS].zero;
    end
  end

endmodule

/* sv/ortho3_proj.sv */
// Pipelined projection removal: subtracts from a vector its component along a unit vector.
module ortho3_proj import ortho3_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  vec_comp_t  tin [3],
  input  unit_comp_t uin [3],
  output vec_comp_t  tout [3]
);

  localparam int PROD_W = VEC_W + UNIT_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int K_W    = 34;
  localparam int KU_W   = K_W + UNIT_W;

  // Round half away from zero while dropping FRAC bits.
  function automatic logic signed [K_W-1:0] round_dot(input logic signed [DOT_W-1:0] x);
    logic [DOT_W-1:0] m;
    logic [DOT_W-1:0] r;
    m = x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
    r = (m + (DOT_W'(1) << (FRAC - 1))) >> FRAC;
    round_dot = x[DOT_W-1] ? -$signed(r[K_W-1:0]) : $signed(r[K_W-1:0]);
  endfunction

  function automatic vec_comp_t round_ku(input logic signed [KU_W-1:0] x);
    logic [KU_W-1:0] m;
    logic [KU_W-1:0] r;
    m = x[KU_W-1] ? KU_W'(-x) : KU_W'(x);
    r = (m + (KU_W'(1) << (FRAC - 1))) >> FRAC;
    round_ku = x[KU_W-1] ? -$signed(r[VEC_W-1:0]) : $signed(r[VEC_W-1:0]);
  endfunction

  logic signed [PROD_W-1:0] p1_prod [3];
  vec_comp_t                p1_t [3];
  unit_comp_t               p1_u [3];
  logic signed [DOT_W-1:0]  p2_dot;
  vec_comp_t                p2_t [3];
  unit_comp_t               p2_u [3];
  logic signed [K_W-1:0]    p3_k;
  vec_comp_t                p3_t [3];
  unit_comp_t               p3_u [3];
  logic signed [KU_W-1:0]   p4_ku [3];
  vec_comp_t                p4_t [3];

  always_ff @(posedge clk) begin
    if (en) begin
      // Component products of the dot product.
      for (int i = 0; i < 3; i++) begin
        p1_prod[i] <= tin[i] * uin[i];
      end
      p1_t <= tin;
      p1_u <= uin;
      // Dot product.
      p2_dot <= DOT_W'(p1_prod[0]) + DOT_W'(p1_prod[1]) + DOT_W'(p1_prod[2]);
      p2_t   <= p1_t;
      p2_u   <= p1_u;
      // Projection coefficient.
      p3_k <= round_dot(p2_dot);
      p3_t <= p2_t;
      p3_u <= p2_u;
      // Scaled unit vector.
      for (int i = 0; i < 3; i++) begin
        p4_ku[i] <= p3_k * p3_u[i];
      end
      p4_t <= p3_t;
      // Residual.
      for (int i = 0; i < 3; i++) begin
        tout[i] <= p4_t[i] - round_ku(p4_ku[i]);
      end
    end
  end

endmodule

/* sv/orthonormalize_three_axes_unit.sv */
// Top level of the three-axis Gram-Schmidt orthonormalization pipeline.
// Throughput: one word per cycle while no output word waits; the longest path
// is three normalizers in series, each with 32 square-root stages and 31 division
// stages. The whole pipeline holds while an output word waits; reset clears only
// valid bits.
`include "orthonormalize_three_axes_unit_assert.svh"

module orthonormalize_three_axes_unit import ortho3_pkg::*; #(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [IN_WIDTH-1:0] axis1_x,
  input  logic signed [IN_WIDTH-1:0] axis1_y,
  input  logic signed [IN_WIDTH-1:0] axis1_z,
  input  logic signed [IN_WIDTH-1:0] axis2_x,
  input  logic signed [IN_WIDTH-1:0] axis2_y,
  input  logic signed [IN_WIDTH-1:0] axis2_z,
  input  logic signed [IN_WIDTH-1:0] axis3_x,
  input  logic signed [IN_WIDTH-1:0] axis3_y,
  input  logic signed [IN_WIDTH-1:0] axis3_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    unit1_x,
  output logic signed [OUT_W-1:0]    unit1_y,
  output logic signed [OUT_W-1:0]    unit1_z,
  output logic signed [OUT_W-1:0]    unit2_x,
  output logic signed [OUT_W-1:0]    unit2_y,
  output logic signed [OUT_W-1:0]    unit2_z,
  output logic signed [OUT_W-1:0]    unit3_x,
  output logic signed [OUT_W-1:0]    unit3_y,
  output logic signed [OUT_W-1:0]    unit3_z,
  output logic                       degenerate
);

  localparam int LAT    = 3 * NORM_LAT + 2 * PROJ_LAT + 1;
  localparam int U1_DLY = 2 * NORM_LAT + 2 * PROJ_LAT;
  localparam int U2_DLY = NORM_LAT + PROJ_LAT;
  localparam int T3_DLY = NORM_LAT;
  localparam int EXT_W  = VEC_W - IN_WIDTH;

  // Round Q2.30 to Q2.14, half away from zero, and clamp to one.
  function automatic logic signed [OUT_W-1:0] to_q14(input unit_comp_t u);
    logic [UNIT_W-1:0] m;
    logic [UNIT_W-1:0] r;
    m = u[UNIT_W-1] ? UNIT_W'(-u) : UNIT_W'(u);
    r = (m + (UNIT_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (r > UNIT_W'(OUT_MAX)) begin
      r = UNIT_W'(OUT_MAX);
    end
    to_q14 = u[UNIT_W-1] ? -$signed(r[OUT_W-1:0]) : $signed(r[OUT_W-1:0]);
  endfunction

  // Global advance: every stage moves unless a finished word is waiting.
  logic en;
  logic [LAT-1:0] vld;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en && !rst;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Sign-extend the input axes to the internal component width.
  vec_comp_t a1 [3];
  vec_comp_t a2 [3];
  vec_comp_t a3 [3];

  assign a1[0] = {{EXT_W{axis1_x[IN_WIDTH-1]}}, axis1_x};
  assign a1[1] = {{EXT_W{axis1_y[IN_WIDTH-1]}}, axis1_y};
  assign a1[2] = {{EXT_W{axis1_z[IN_WIDTH-1]}}, axis1_z};
  assign a2[0] = {{EXT_W{axis2_x[IN_WIDTH-1]}}, axis2_x};
  assign a2[1] = {{EXT_W{axis2_y[IN_WIDTH-1]}}, axis2_y};
  assign a2[2] = {{EXT_W{axis2_z[IN_WIDTH-1]}}, axis2_z};
  assign a3[0] = {{EXT_W{axis3_x[IN_WIDTH-1]}}, axis3_x};
  assign a3[1] = {{EXT_W{axis3_y[IN_WIDTH-1]}}, axis3_y};
  assign a3[2] = {{EXT_W{axis3_z[IN_WIDTH-1]}}, axis3_z};

  // First pass: normalize all three input axes side by side.
  unit_comp_t u1 [3];
  unit_comp_t n2 [3];
  unit_comp_t n3 [3];
  logic       z1;
  logic       z2a;
  logic       z3a;

  ortho3_norm u_norm1 (.clk, .en, .use_tol(1'b0), .vin(a1), .uout(u1), .zero(z1));
  ortho3_norm u_norm2 (.clk, .en, .use_tol(1'b0), .vin(a2), .uout(n2), .zero(z2a));
  ortho3_norm u_norm3 (.clk, .en, .use_tol(1'b0), .vin(a3), .uout(n3), .zero(z3a));

  vec_comp_t t2 [3];
  vec_comp_t t3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t2[i] = vec_comp_t'(n2[i]);
      t3[i] = vec_comp_t'(n3[i]);
    end
  end

  // Remove the first axis from the second and third.
  vec_comp_t t2p [3];
  vec_comp_t t3p [3];

  ortho3_proj u_proj21 (.clk, .en, .tin(t2), .uin(u1), .tout(t2p));
  ortho3_proj u_proj31 (.clk, .en, .tin(t3), .uin(u1), .tout(t3p));

  // Second axis is final after its normalizer.
  unit_comp_t u2 [3];
  logic       z2b;

  ortho3_norm u_norm4 (.clk, .en, .use_tol(1'b1), .vin(t2p), .uout(u2), .zero(z2b));

  // Third-axis residual waits for the second unit axis.
  vec_comp_t t3_line [T3_DLY][3];

  always_ff @(posedge clk) begin
    if (en) begin
      t3_line[0] <= t3p;
      for (int i = 1; i < T3_DLY; i++) begin
        t3_line[i] <= t3_line[i-1];
      end
    end
  end

  vec_comp_t  t3pp [3];
  unit_comp_t u3 [3];
  logic       z3b;

  ortho3_proj u_proj32 (.clk, .en, .tin(t3_line[T3_DLY-1]), .uin(u2), .tout(t3pp));
  ortho3_norm u_norm5 (.clk, .en, .use_tol(1'b1), .vin(t3pp), .uout(u3), .zero(z3b));

  // Earlier results wait for the third axis; the early flags ride along.
  unit_comp_t        u1_line [U1_DLY][3];
  logic [U1_DLY-1:0] ze_line;
  unit_comp_t        u2_line [U2_DLY][3];
  logic [U2_DLY-1:0] z2_line;

  always_ff @(posedge clk) begin
    if (en) begin
      u1_line[0] <= u1;
      for (int i = 1; i < U1_DLY; i++) begin
        u1_line[i] <= u1_line[i-1];
      end
      ze_line <= {ze_line[U1_DLY-2:0], z1 | z2a | z3a};
      u2_line[0] <= u2;
      for (int i = 1; i < U2_DLY; i++) begin
        u2_line[i] <= u2_line[i-1];
      end
      z2_line <= {z2_line[U2_DLY-2:0], z2b};
    end
  end

  // Output register: convert to Q2.14 and merge the degenerate flags.
  always_ff @(posedge clk) begin
    if (en) begin
      unit1_x    <= to_q14(u1_line[U1_DLY-1][0]);
      unit1_y    <= to_q14(u1_line[U1_DLY-1][1]);
      unit1_z    <= to_q14(u1_line[U1_DLY-1][2]);
      unit2_x    <= to_q14(u2_line[U2_DLY-1][0]);
      unit2_y    <= to_q14(u2_line[U2_DLY-1][1]);
      unit2_z    <= to_q14(u2_line[U2_DLY-1][2]);
      unit3_x    <= to_q14(u3[0]);
      unit3_y    <= to_q14(u3[1]);
      unit3_z    <= to_q14(u3[2]);
      degenerate <= ze_line[U1_DLY-1] | z2_line[U2_DLY-1] | z3b;
    end
  end

  // A word taken at the input enters the first valid stage.
  `ORTHO3_ASSERT_NEXT(a_take_enters, in_valid && in_ready, vld[0], "accepted word lost at entry")
  // A non-degenerate set has nonzero first and third axes.
  `ORTHO3_ASSERT_IMPLY(a_unit1_live, out_valid && !degenerate, unit1_x != 0 || unit1_y != 0 || unit1_z != 0, "zero first axis without degenerate flag")
  `ORTHO3_ASSERT_IMPLY(a_unit3_live, out_valid && !degenerate, unit3_x != 0 || unit3_y != 0 || unit3_z != 0, "zero third axis without degenerate flag")
  // A zero second axis must be flagged.
  `ORTHO3_ASSERT_IMPLY(a_unit2_flag, out_valid && unit2_x == 0 && unit2_y == 0 && unit2_z == 0, degenerate, "zero second axis not flagged")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the three-axis Gram-Schmidt orthonormalization unit.
module testbench import ortho3_pkg::*; ();

  localparam int AW = 16;
  localparam int LATENCY = 221;
  localparam int WATCHDOG = 4000;
  localparam int RANDOM_WORDS = 1230;
  localparam int NUM_ROWS = 11;

  typedef logic signed [AW-1:0] comp_t;
  typedef struct {
    comp_t a [9];
  } triple_t;
  typedef struct {
    logic signed [OUT_W-1:0] u [9];
    logic degen;
  } frame_t;
  typedef struct {
    triple_t t;
    bit has_fixed;
    frame_t fixed;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  comp_t axis [9];
  logic out_valid;
  logic out_ready;
  logic signed [OUT_W-1:0] unit [9];
  logic degenerate;

  frame_t frame_queue [$];
  int errors;
  int idle_cycles;
  bit sending_done;

  orthonormalize_three_axes_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .axis1_x(axis[0]), .axis1_y(axis[1]), .axis1_z(axis[2]),
    .axis2_x(axis[3]), .axis2_y(axis[4]), .axis2_z(axis[5]),
    .axis3_x(axis[6]), .axis3_y(axis[7]), .axis3_z(axis[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .unit1_x(unit[0]), .unit1_y(unit[1]), .unit1_z(unit[2]),
    .unit2_x(unit[3]), .unit2_y(unit[4]), .unit2_z(unit[5]),
    .unit3_x(unit[6]), .unit3_y(unit[7]), .unit3_z(unit[8]),
    .degenerate(degenerate)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Magnitude of a signed 64-bit value.
  function automatic longint unsigned mag_of(longint x);
    return x < 0 ? -x : x;
  endfunction

  // Right shift with rounding half away from zero.
  function automatic longint round_shift(longint x, int s);
    longint unsigned m;
    m = (mag_of(x) + (64'd1 << (s - 1))) >> s;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Bitwise floor square root.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scales a vector to Q2.30 unit length; returns 0 when it is too short.
  function automatic bit normalize(input longint v [3], output longint u [3],
                                   input longint unsigned tol);
    longint c [3];
    longint unsigned m, sum, nrm, q;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = v[i];
      if (c[i] > (64'sd1 <<< 31)) c[i] = 64'sd1 <<< 31;
      if (c[i] < -(64'sd1 <<< 31)) c[i] = -(64'sd1 <<< 31);
      if (mag_of(c[i]) > m) m = mag_of(c[i]);
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (m <= tol) return 0;
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) c[i] *= 2;
    end
    for (int i = 0; i < 3; i++) sum += mag_of(c[i]) * mag_of(c[i]);
    nrm = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag_of(c[i]) << 30) + (nrm >> 1)) / nrm;
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  // Removes the component of v along unit vector u.
  function automatic void remove_projection(ref longint v [3], input longint u [3]);
    longint dot, k;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += v[i] * u[i];
    k = round_shift(dot, 30);
    for (int i = 0; i < 3; i++) v[i] -= round_shift(k * u[i], 30);
  endfunction

  // Computes the orthonormal frame that one triple must produce.
  function automatic frame_t orthonormal_frame(triple_t t);
    frame_t f;
    longint a [3][3];
    longint u [3][3];
    longint w [3];
    longint r;
    bit ok;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = t.a[i*3+j];
    ok = normalize(a[0], u[0], 0);
    if (normalize(a[1], w, 0)) begin
      remove_projection(w, u[0]);
      ok &= normalize(w, u[1], DEGEN_TOL);
    end else begin
      u[1] = '{0, 0, 0};
      ok = 0;
    end
    if (normalize(a[2], w, 0)) begin
      remove_projection(w, u[0]);
      remove_projection(w, u[1]);
      ok &= normalize(w, u[2], DEGEN_TOL);
    end else begin
      u[2] = '{0, 0, 0};
      ok = 0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        r = round_shift(u[i][j], OUT_SHIFT);
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < -OUT_MAX) r = -OUT_MAX;
        f.u[i*3+j] = r[OUT_W-1:0];
      end
    f.degen = !ok;
    return f;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 15) - 8);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Random triple, sometimes with a zero axis or parallel axes.
  function automatic triple_t rand_triple();
    triple_t t;
    int k;
    for (int i = 0; i < 9; i++) t.a[i] = rand_comp();
    k = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0: for (int j = 0; j < 3; j++) t.a[k*3+j] = 0;
      1: for (int j = 0; j < 3; j++) t.a[k*3+j] = t.a[((k+1)%3)*3+j];
      2: for (int j = 0; j < 3; j++) t.a[k*3+j] = -t.a[((k+1)%3)*3+j];
      default: ;
    endcase
    return t;
  endfunction

  // Random idle gap before one word, often none.
  function automatic int next_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
  endfunction

  function automatic row_t mk_row(int v [9], bit fx, int e [9], bit dg);
    row_t r;
    for (int i = 0; i < 9; i++) begin
      r.t.a[i] = comp_t'(v[i]);
      r.fixed.u[i] = OUT_W'(e[i]);
    end
    r.has_fixed = fx;
    r.fixed.degen = dg;
    return r;
  endfunction

  // Offers one word after an idle gap and waits for it to be taken.
  task automatic send_word(triple_t t, frame_t e, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    for (int i = 0; i < 9; i++) axis[i] <= t.a[i];
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_queue.insert(frame_queue.size(), e);
    @(negedge clk);
  endtask

  // Sender: a directed table, then random triples.
  initial begin
    row_t rows [NUM_ROWS];
    triple_t t;
    rst = 1;
    in_valid = 0;
    for (int i = 0; i < 9; i++) axis[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // Identity frame, all-zero input, parallel axes, extremes, zero axes.
    rows[0] = mk_row('{4096, 0, 0, 0, 4096, 0, 0, 0, 4096}, 1,
      '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 0);
    rows[1] = mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1);
    rows[2] = mk_row('{4096, 0, 0, 8192, 0, 0, 0, 0, 4096}, 1,
      '{16384, 0, 0, 0, 0, 0, 0, 0, 16384}, 1);
    rows[3] = mk_row('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 1,
      '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 0);
    rows[4] = mk_row('{32767, 0, 0, 0, 32767, 0, 0, 0, 0}, 1,
      '{16384, 0, 0, 0, 16384, 0, 0, 0, 0}, 1);
    rows[5] = mk_row('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1,
      '{0, 0, 0, 16384, 0, 0, 0, 16384, 0}, 1);
    rows[6] = mk_row('{32767, 32767, 32767, -32768, -32768, -32768, 1, -1, 1}, 0,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0);
    rows[7] = mk_row('{1, 1, 1, -1, 1, 0, 1, 1, -2}, 0,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0);
    rows[8] = mk_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0);
    rows[9] = mk_row('{32767, 1, 0, 32767, 0, 0, 0, 0, 1}, 0,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0);
    rows[10] = mk_row('{21845, -10923, 5461, -21846, 10922, -5462, 1234, -4321, 777}, 0,
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0);
    foreach (rows[n]) begin
      frame_t f;
      f = orthonormal_frame(rows[n].t);
      if (rows[n].has_fixed) begin
        if (f.u != rows[n].fixed.u || f.degen != rows[n].fixed.degen) begin
          $error("directed row %0d: table value disagrees with prediction", n);
          errors++;
        end
        send_word(rows[n].t, rows[n].fixed, next_gap());
      end else begin
        send_word(rows[n].t, f, next_gap());
      end
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      t = rand_triple();
      send_word(t, orthonormal_frame(t), next_gap());
    end
    in_valid <= 0;
    sending_done = 1;
  end

  // Receiver: random stalls, with one long hold-off that freezes the pipeline.
  initial begin
    int stall;
    int words;
    out_ready = 0;
    words = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (words == 40) begin
        out_ready <= 0;
        repeat (600) @(negedge clk);
      end
      stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words++;
      @(negedge clk);
    end
  end

  // Checker and watchdog on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (frame_queue.size() == 0) begin
          $error("output word with no expected frame");
          errors++;
        end else begin
          frame_t e;
          e = frame_queue.pop_front();
          for (int i = 0; i < 9; i++)
            if (unit[i] !== e.u[i]) begin
              $error("unit%0d_%s: expected %0d, actual %0d", i / 3 + 1,
                     (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z", e.u[i], unit[i]);
              errors++;
            end
          if (degenerate !== e.degen) begin
            $error("degenerate: expected %0d, actual %0d", e.degen, degenerate);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    sending_done = 0;
    fork
      begin
        wait (sending_done && frame_queue.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (frame_queue.size() != 0) begin
          $error("%0d expected frames never arrived", frame_queue.size());
          errors++;
        end
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("Regression FAIL");
      end
    join_any
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/ortho3_pkg.sv
sv/ortho3_norm.sv
sv/ortho3_proj.sv
sv/orthonormalize_three_axes_unit.sv
test/testbench.sv
